// ===== sv/jsp_pkg.sv =====
// ----------------------------------------------------------------------------
// jsp_pkg
// Shared types, constants and register indexes of the joint slew positioner.
// ----------------------------------------------------------------------------
package jsp_pkg;

    localparam int NUM_JOINTS   = 6;
    localparam int ANGLE_BITS   = 16;
    localparam int OUT_JOINTS   = 6;   // angle ports on the result beat
    localparam int LIM_JOINTS   = 6;   // joints that have limits
    localparam int LIM_BITS     = 16;
    localparam int LIM_SLOTS    = 3;   // limits packed per register
    localparam int STEP_BITS    = 15;
    localparam int CFG_BITS     = 48;
    localparam int CFG_IDX_BITS = 3;
    localparam int JOINT_BITS   = 3;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_STEP_NORMAL = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_STEP_DEMO   = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_DEMO_MODE   = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_LOW_A       = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_LOW_B       = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_HIGH_A      = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_HIGH_B      = 3'd6;

    // request codes
    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_SET  = 1'b1;

    // register reset values
    localparam logic [STEP_BITS-1:0] STEP_NORMAL_RST = 15'd200;
    localparam logic [STEP_BITS-1:0] STEP_DEMO_RST   = 15'd100;
    localparam logic [CFG_BITS-1:0]  LOW_LIM_RST     = 48'd204168680749488;
    localparam logic [CFG_BITS-1:0]  HIGH_LIM_RST    = 48'd77310590994000;

    // motion and collision thresholds, 0.01 degree units
    localparam int SNAP_BAND  = 10;
    localparam int COL_J1_HI  = 10000;
    localparam int COL_J1_LO  = -10000;
    localparam int COL_J2_HI  = 15500;
    localparam int HOME_JOINT = 2;
    localparam int HOME_ANGLE = 9000;

    typedef logic signed [ANGLE_BITS-1:0] t_angle;

    // one row of state: everything the positioner keeps
    typedef struct packed {
        logic                                  col;
        logic [NUM_JOINTS-1:0][ANGLE_BITS-1:0] tgt;
        logic [NUM_JOINTS-1:0][ANGLE_BITS-1:0] cur;
    } t_row;

    localparam int ROW_BITS = $bits(t_row);

    typedef struct packed {
        logic [STEP_BITS-1:0] step_normal;
        logic [STEP_BITS-1:0] step_demo;
        logic                 demo_mode;
        logic [CFG_BITS-1:0]  lo_a;
        logic [CFG_BITS-1:0]  lo_b;
        logic [CFG_BITS-1:0]  hi_a;
        logic [CFG_BITS-1:0]  hi_b;
    } t_cfg;

    typedef struct packed {
        logic                  req_type;
        logic [JOINT_BITS-1:0] joint;
        logic [ANGLE_BITS-1:0] angle;
    } t_req;

    typedef struct packed {
        logic [OUT_JOINTS-1:0][ANGLE_BITS-1:0] ang;
        logic                                  col;
        logic [ANGLE_BITS-1:0]                 stored;
    } t_res;

    localparam int RES_BITS = $bits(t_res);

    function automatic t_row row_reset();
        t_row r;
        r = '0;
        for (int j = 0; j < NUM_JOINTS; j++) begin
            if (j == HOME_JOINT) begin
                r.cur[j] = ANGLE_BITS'(HOME_ANGLE);
                r.tgt[j] = ANGLE_BITS'(HOME_ANGLE);
            end
        end
        return r;
    endfunction

    localparam t_row ROW_RESET = row_reset();

endpackage

// ===== sv/jsp_ram.sv =====
// ----------------------------------------------------------------------------
// jsp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module jsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/jsp_step.sv =====
// ----------------------------------------------------------------------------
// jsp_step
// Next-state datapath: target clamp, collision check and per-joint slew lanes.
// ----------------------------------------------------------------------------
module jsp_step (
    input  jsp_pkg::t_row i_row,
    input  jsp_pkg::t_req i_req,
    input  jsp_pkg::t_cfg i_cfg,
    output jsp_pkg::t_row o_row,
    output jsp_pkg::t_res o_res
);

    localparam int DW = jsp_pkg::ANGLE_BITS + 1;

    logic signed [jsp_pkg::LIM_BITS-1:0]   lo_lim [jsp_pkg::LIM_JOINTS];
    logic signed [jsp_pkg::LIM_BITS-1:0]   hi_lim [jsp_pkg::LIM_JOINTS];
    logic signed [jsp_pkg::LIM_BITS-1:0]   sel_lo;
    logic signed [jsp_pkg::LIM_BITS-1:0]   sel_hi;
    logic                                  jvalid;
    jsp_pkg::t_angle                       clamped;
    jsp_pkg::t_angle                       pre_ext [jsp_pkg::OUT_JOINTS];
    logic [jsp_pkg::STEP_BITS-1:0]         st;
    logic [DW-1:0]                         st_x;
    logic signed [DW-1:0]                  diff [jsp_pkg::NUM_JOINTS];
    logic [DW-1:0]                         mag  [jsp_pkg::NUM_JOINTS];
    logic [jsp_pkg::NUM_JOINTS-1:0][jsp_pkg::ANGLE_BITS-1:0] moved;
    logic                                  col_now;

    // limits unpacked from the packed registers
    always_comb begin
        for (int j = 0; j < jsp_pkg::LIM_JOINTS; j++) begin
            if (j < jsp_pkg::LIM_SLOTS) begin
                lo_lim[j] = i_cfg.lo_a[(j % jsp_pkg::LIM_SLOTS)*jsp_pkg::LIM_BITS +:
                                       jsp_pkg::LIM_BITS];
                hi_lim[j] = i_cfg.hi_a[(j % jsp_pkg::LIM_SLOTS)*jsp_pkg::LIM_BITS +:
                                       jsp_pkg::LIM_BITS];
            end else begin
                lo_lim[j] = i_cfg.lo_b[(j % jsp_pkg::LIM_SLOTS)*jsp_pkg::LIM_BITS +:
                                       jsp_pkg::LIM_BITS];
                hi_lim[j] = i_cfg.hi_b[(j % jsp_pkg::LIM_SLOTS)*jsp_pkg::LIM_BITS +:
                                       jsp_pkg::LIM_BITS];
            end
        end
    end

    // set target: clamp low first, then high, so high wins on crossed limits
    always_comb begin
        sel_lo = '0;
        sel_hi = '0;
        jvalid = 1'b0;
        for (int j = 0; j < jsp_pkg::LIM_JOINTS; j++) begin
            if (j < jsp_pkg::NUM_JOINTS && i_req.joint == jsp_pkg::JOINT_BITS'(j)) begin
                sel_lo = lo_lim[j];
                sel_hi = hi_lim[j];
                jvalid = 1'b1;
            end
        end
        clamped = i_req.angle;
        if (clamped < sel_lo) begin
            clamped = sel_lo;
        end
        if (clamped > sel_hi) begin
            clamped = sel_hi;
        end
    end

    // pre-step angles; missing joints read as zero
    always_comb begin
        for (int j = 0; j < jsp_pkg::OUT_JOINTS; j++) begin
            pre_ext[j] = '0;
        end
        for (int j = 0; j < jsp_pkg::NUM_JOINTS && j < jsp_pkg::OUT_JOINTS; j++) begin
            pre_ext[j] = i_row.cur[j];
        end
        col_now = (pre_ext[1] > jsp_pkg::ANGLE_BITS'(jsp_pkg::COL_J1_HI))
               || (pre_ext[1] < jsp_pkg::ANGLE_BITS'(jsp_pkg::COL_J1_LO))
               || (pre_ext[2] > jsp_pkg::ANGLE_BITS'(jsp_pkg::COL_J2_HI));
    end

    // slew lanes, one per joint
    always_comb begin
        st   = i_cfg.demo_mode ? i_cfg.step_demo : i_cfg.step_normal;
        st_x = DW'(st);
        for (int j = 0; j < jsp_pkg::NUM_JOINTS; j++) begin
            diff[j] = DW'($signed(i_row.tgt[j])) - DW'($signed(i_row.cur[j]));
            mag[j]  = diff[j][DW-1] ? DW'(-diff[j]) : DW'(diff[j]);
            if (mag[j] > DW'(jsp_pkg::SNAP_BAND) && mag[j] > st_x) begin
                if (diff[j][DW-1]) begin
                    moved[j] = i_row.cur[j] - jsp_pkg::ANGLE_BITS'(st);
                end else begin
                    moved[j] = i_row.cur[j] + jsp_pkg::ANGLE_BITS'(st);
                end
            end else begin
                moved[j] = i_row.tgt[j];
            end
        end
    end

    always_comb begin
        o_row = i_row;
        if (i_req.req_type == jsp_pkg::REQ_SET) begin
            for (int j = 0; j < jsp_pkg::NUM_JOINTS; j++) begin
                if (jvalid && i_req.joint == jsp_pkg::JOINT_BITS'(j)) begin
                    o_row.tgt[j] = clamped;
                end
            end
        end else begin
            o_row.col = col_now;
            o_row.cur = moved;
        end

        o_res.ang = '0;
        for (int j = 0; j < jsp_pkg::NUM_JOINTS && j < jsp_pkg::OUT_JOINTS; j++) begin
            o_res.ang[j] = o_row.cur[j];
        end
        o_res.col    = o_row.col;
        o_res.stored = (i_req.req_type == jsp_pkg::REQ_SET && jvalid) ? clamped : '0;
    end

endmodule

// ===== sv/joint_slew_positioner.sv =====
// A beat goes through the update stage registers into the result buffer.
// Throughput: one item per cycle unless the result channel stalls; each beat
//   reads, updates, writes back the row, the write bypassing into the next read.
// Reset (i_rst_n low, synchronous): registers to defaults, state row reads as
//   home pose (joint 2 at 90 degrees), output buffer empty. No clearing pass.
// ----------------------------------------------------------------------------
// joint_slew_positioner
// Six-joint slew-limited positioner. Set-target beats store a clamped target;
// tick beats run the collision check and step every joint toward its target.
// ----------------------------------------------------------------------------
module joint_slew_positioner (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration write port
    input  logic                                  i_cfg_we,
    input  logic [jsp_pkg::CFG_IDX_BITS-1:0]      i_cfg_idx,
    input  logic [jsp_pkg::CFG_BITS-1:0]          i_cfg_data,
    // input channel
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic                                  i_req_type,
    input  logic [jsp_pkg::JOINT_BITS-1:0]        i_joint,
    input  logic signed [jsp_pkg::ANGLE_BITS-1:0] i_angle,
    // result channel
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [jsp_pkg::ANGLE_BITS-1:0] o_angle_j0,
    output logic signed [jsp_pkg::ANGLE_BITS-1:0] o_angle_j1,
    output logic signed [jsp_pkg::ANGLE_BITS-1:0] o_angle_j2,
    output logic signed [jsp_pkg::ANGLE_BITS-1:0] o_angle_j3,
    output logic signed [jsp_pkg::ANGLE_BITS-1:0] o_angle_j4,
    output logic signed [jsp_pkg::ANGLE_BITS-1:0] o_angle_j5,
    output logic                                  o_collision,
    output logic signed [jsp_pkg::ANGLE_BITS-1:0] o_stored_target
);

    // the whole state is one row of the state RAM
    localparam logic ROW_ADDR = 1'b0;

    // ---------------- configuration registers ----------------
    jsp_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.step_normal <= jsp_pkg::STEP_NORMAL_RST;
            r_cfg.step_demo   <= jsp_pkg::STEP_DEMO_RST;
            r_cfg.demo_mode   <= 1'b0;
            r_cfg.lo_a        <= jsp_pkg::LOW_LIM_RST;
            r_cfg.lo_b        <= jsp_pkg::LOW_LIM_RST;
            r_cfg.hi_a        <= jsp_pkg::HIGH_LIM_RST;
            r_cfg.hi_b        <= jsp_pkg::HIGH_LIM_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                jsp_pkg::REG_STEP_NORMAL: r_cfg.step_normal <= i_cfg_data[jsp_pkg::STEP_BITS-1:0];
                jsp_pkg::REG_STEP_DEMO:   r_cfg.step_demo   <= i_cfg_data[jsp_pkg::STEP_BITS-1:0];
                jsp_pkg::REG_DEMO_MODE:   r_cfg.demo_mode   <= i_cfg_data[0];
                jsp_pkg::REG_LOW_A:       r_cfg.lo_a        <= i_cfg_data;
                jsp_pkg::REG_LOW_B:       r_cfg.lo_b        <= i_cfg_data;
                jsp_pkg::REG_HIGH_A:      r_cfg.hi_a        <= i_cfg_data;
                jsp_pkg::REG_HIGH_B:      r_cfg.hi_b        <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // ---------------- handshake and output buffer control ----------------
    // Two-entry result buffer. The beat in the update stage always has a slot
    // reserved, so the stage never stalls and the RAM write follows its valid.
    logic       r_s1_v;
    logic [1:0] r_cnt;
    logic       r_wp;
    logic       r_rp;
    logic       in_acc;
    logic       out_pop;
    logic [1:0] occ;

    assign out_pop    = o_out_valid && !i_out_stall;
    assign occ        = r_cnt + 2'(r_s1_v);
    assign o_in_stall = (occ - 2'(out_pop)) > 2'd1;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign o_out_valid = (r_cnt != 2'd0);

    // ---------------- update stage: request registers ----------------
    jsp_pkg::t_req r_s1_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else begin
            r_s1_v <= in_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_req.req_type <= i_req_type;
            r_s1_req.joint    <= i_joint;
            r_s1_req.angle    <= i_angle;
        end
    end

    // ---------------- state RAM read-modify-write ----------------
    logic [jsp_pkg::ROW_BITS-1:0] ram_rdata;
    jsp_pkg::t_row                s1_row;
    jsp_pkg::t_row                wr_row;
    jsp_pkg::t_res                s1_res;
    jsp_pkg::t_row                r_byp_row;
    logic                         r_byp;      // write landed on the read edge
    logic                         r_row_vld;  // row written since reset

    jsp_ram #(
        .WIDTH (jsp_pkg::ROW_BITS),
        .DEPTH (1)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (r_s1_v),
        .i_waddr (ROW_ADDR),
        .i_wdata (wr_row),
        .i_re    (in_acc),
        .i_raddr (ROW_ADDR),
        .o_rdata (ram_rdata)
    );

    // Read data misses a write made on the same edge: forward it. Before the
    // first write the row reads as the home pose.
    always_comb begin
        if (r_byp) begin
            s1_row = r_byp_row;
        end else if (r_row_vld) begin
            s1_row = jsp_pkg::t_row'(ram_rdata);
        end else begin
            s1_row = jsp_pkg::ROW_RESET;
        end
    end

    jsp_step u_step (
        .i_row (s1_row),
        .i_req (r_s1_req),
        .i_cfg (r_cfg),
        .o_row (wr_row),
        .o_res (s1_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byp     <= 1'b0;
            r_row_vld <= 1'b0;
        end else begin
            r_byp <= r_s1_v;
            if (r_s1_v) begin
                r_row_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_v) begin
            r_byp_row <= wr_row;
        end
    end

    // ---------------- result buffer ----------------
    logic [jsp_pkg::RES_BITS-1:0] r_buf [2];
    jsp_pkg::t_res                head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
        end else begin
            r_cnt <= r_cnt + 2'(r_s1_v) - 2'(out_pop);
            if (r_s1_v) begin
                r_wp <= !r_wp;
            end
            if (out_pop) begin
                r_rp <= !r_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_v) begin
            r_buf[r_wp] <= s1_res;
        end
    end

    assign head            = jsp_pkg::t_res'(r_buf[r_rp]);
    assign o_angle_j0      = head.ang[0];
    assign o_angle_j1      = head.ang[1];
    assign o_angle_j2      = head.ang[2];
    assign o_angle_j3      = head.ang[3];
    assign o_angle_j4      = head.ang[4];
    assign o_angle_j5      = head.ang[5];
    assign o_collision     = head.col;
    assign o_stored_target = head.stored;

`ifndef SYNTH
    // buffer never holds more than its two entries
    a_cnt_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("result buffer overflow");

    // every accepted beat reaches the update stage next cycle
    a_acc_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_s1_v)
        else $error("accepted beat lost before update");

    // back-to-back beats must take the forwarded row
    a_bypass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && r_s1_v) |=> r_byp)
        else $error("missing write-to-read forward");

    // a set-target beat leaves the collision flag alone
    a_set_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_v && r_s1_req.req_type == jsp_pkg::REQ_SET) |-> (wr_row.col == s1_row.col))
        else $error("set-target beat changed collision flag");

    // no room, no accept
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2 && !out_pop) |-> !in_acc)
        else $error("beat accepted with full buffer");
`endif

endmodule
